### design/efbf_pkg.sv
// Shared types and constants for the escaped frame byte FIFO.
`timescale 1ns / 1ps
package efbf_pkg;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_INJECT = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   localparam logic [7:0] DELIM = 8'h7E;
   localparam logic [7:0] ESC   = 8'h7D;
   localparam logic [7:0] FLIP  = 8'h20;

   localparam int unsigned MAX_FRAME_BYTES = 4;

   typedef enum logic [1:0] {
      CMD_PUSH,
      CMD_INJECT,
      CMD_POP,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type    kind;
      logic [2:0]      len;
      logic [3:0][7:0] enc;
   } cmd_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] read_byte;
      logic [1:0] status;
      logic [9:0] frame_level;
      logic [10:0] byte_level;
   } res_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WRITE,
      BK_READ,
      BK_TAKE,
      BK_PEEK_READ,
      BK_PEEK,
      BK_REPLY
   } back_state_type;

endpackage

### design/efbf_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module efbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

### design/efbf_front.sv
// Front end: accepts request beats, encodes them and queues them for the back end.
`timescale 1ns / 1ps
module efbf_front
   import efbf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_data_byte,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_take
);

   cmd_type    entries_ff [2];
   logic       head_ff, head_in;
   logic [1:0] count_ff, count_in;
   logic       tail;
   logic       enq;
   logic       deq;
   cmd_type    new_cmd;

   always_comb begin
      new_cmd.kind = CMD_NOP;
      new_cmd.len  = 3'd0;
      new_cmd.enc  = '0;
      case (req_operation)
         OP_PUSH: begin
            new_cmd.kind   = CMD_PUSH;
            new_cmd.enc[0] = DELIM;
            if (req_data_byte == DELIM || req_data_byte == ESC) begin
               new_cmd.len    = 3'd4;
               new_cmd.enc[1] = ESC;
               new_cmd.enc[2] = req_data_byte ^ FLIP;
               new_cmd.enc[3] = DELIM;
            end else begin
               new_cmd.len    = 3'd3;
               new_cmd.enc[1] = req_data_byte;
               new_cmd.enc[2] = DELIM;
            end
         end
         OP_INJECT: begin
            new_cmd.kind   = CMD_INJECT;
            new_cmd.len    = 3'd1;
            new_cmd.enc[0] = req_data_byte;
         end
         OP_POP: new_cmd.kind = CMD_POP;
         default: new_cmd.kind = CMD_NOP;
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entries_ff[head_ff];
   assign enq       = push && !full;
   assign deq       = cmd_take && cmd_valid;
   assign tail      = head_ff ^ count_ff[0];

   always_comb begin
      count_in = count_ff + 2'(enq) - 2'(deq);
      head_in  = deq ? !head_ff : head_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         head_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         entries_ff[tail] <= new_cmd;
      end
   end

endmodule

### design/efbf_back.sv
// Back end: writes encoded bytes to the ring, pops and decodes frames, keeps the levels.
`timescale 1ns / 1ps
module efbf_back
   import efbf_pkg::*;
#(
   parameter int STORE_DEPTH = 1024,
   parameter int FRAME_LIMIT = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_take,
   output logic    res_valid,
   output res_type res,
   input  logic    res_ready
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int FW = $clog2(STORE_DEPTH / 2 + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

   back_state_type state_ff, state_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]  fill_ff, fill_in, delims_ff, delims_in;
   logic [FW-1:0]  frames_ff, frames_in;
   logic           last_delim_ff, last_delim_in;
   cmd_type        cmd_ff, cmd_in;
   logic [1:0]     idx_ff, idx_in;
   logic [2:0]     n_ff, n_in;
   logic [7:0]     buf1_ff, buf1_in, buf2_ff, buf2_in;
   logic           p_open_ff, p_open_in, p_pay_ff, p_pay_in;
   logic           acc_ff, acc_in;
   logic [7:0]     rbyte_ff, rbyte_in;
   logic [1:0]     status_ff, status_in;

   logic           ram_en, ram_we;
   logic [AW-1:0]  ram_addr;
   logic [7:0]     ram_wdata, ram_rdata;

   logic [7:0]     wbyte;
   logic           fin, ovl, done;
   logic [7:0]     dec;

   efbf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      next_ptr = (p == LAST_ADDR) ? '0 : p + AW'(1);
   endfunction

   always_comb begin
      state_in      = state_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      fill_in       = fill_ff;
      delims_in     = delims_ff;
      frames_in     = frames_ff;
      last_delim_in = last_delim_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      buf1_in       = buf1_ff;
      buf2_in       = buf2_ff;
      p_open_in     = p_open_ff;
      p_pay_in      = p_pay_ff;
      acc_in        = acc_ff;
      rbyte_in      = rbyte_ff;
      status_in     = status_ff;
      cmd_take      = 1'b0;
      res_valid     = 1'b0;
      ram_en        = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = rd_ptr_ff;
      ram_wdata     = 8'd0;
      wbyte         = cmd_ff.enc[idx_ff];
      fin           = 1'b0;
      ovl           = 1'b0;
      done          = 1'b0;
      dec           = buf2_ff ^ FLIP;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_take  = 1'b1;
               cmd_in    = cmd;
               acc_in    = 1'b0;
               rbyte_in  = 8'd0;
               status_in = ST_OK;
               idx_in    = 2'd0;
               state_in  = BK_REPLY;
               case (cmd.kind)
                  CMD_PUSH: begin
                     if (32'(frames_ff) < 32'(FRAME_LIMIT) &&
                         32'(fill_ff) + 32'(cmd.len) <= 32'(STORE_DEPTH)) begin
                        acc_in   = 1'b1;
                        state_in = BK_WRITE;
                     end
                  end
                  CMD_INJECT: begin
                     if (32'(fill_ff) < 32'(STORE_DEPTH)) begin
                        acc_in   = 1'b1;
                        state_in = BK_WRITE;
                     end
                  end
                  CMD_POP: begin
                     if (fill_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        n_in      = 3'd0;
                        p_open_in = 1'b0;
                        p_pay_in  = 1'b0;
                        state_in  = BK_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_WRITE: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = wr_ptr_ff;
            ram_wdata = wbyte;
            wr_ptr_in = next_ptr(wr_ptr_ff);
            fill_in   = fill_ff + CW'(1);
            if (wbyte == DELIM) begin
               // A delimiter after payload closes the frame at the tail.
               if (delims_ff != '0 && !last_delim_ff) begin
                  frames_in = frames_ff + FW'(1);
               end
               delims_in     = delims_ff + CW'(1);
               last_delim_in = 1'b1;
            end else begin
               last_delim_in = 1'b0;
            end
            idx_in = idx_ff + 2'd1;
            if (3'(idx_ff) == cmd_ff.len - 3'd1) begin
               state_in = BK_REPLY;
            end
         end
         BK_READ: begin
            ram_en   = 1'b1;
            state_in = BK_TAKE;
         end
         BK_TAKE: begin
            rd_ptr_in = next_ptr(rd_ptr_ff);
            fill_in   = fill_ff - CW'(1);
            if (ram_rdata == DELIM) begin
               delims_in = delims_ff - CW'(1);
               if (p_open_ff && p_pay_ff) begin
                  frames_in = frames_ff - FW'(1);
               end
               p_open_in = 1'b1;
               p_pay_in  = 1'b0;
            end else if (p_open_ff) begin
               p_pay_in = 1'b1;
            end
            if (n_ff == 3'd0) begin
               if (ram_rdata == DELIM) begin
                  n_in = 3'd1;
               end
            end else if (32'(n_ff) >= MAX_FRAME_BYTES) begin
               ovl = 1'b1;
               fin = 1'b1;
            end else begin
               if (n_ff == 3'd1) buf1_in = ram_rdata;
               if (n_ff == 3'd2) buf2_in = ram_rdata;
               n_in = n_ff + 3'd1;
               if (ram_rdata == DELIM) begin
                  done = 1'b1;
                  fin  = 1'b1;
               end
            end
            if (fill_in == '0) begin
               fin = 1'b1;
            end
            if (fin) begin
               status_in = ST_INVALID;
               if (done && !ovl) begin
                  if (n_in == 3'd3 && buf1_ff != DELIM && buf1_ff != ESC) begin
                     status_in = ST_OK;
                     rbyte_in  = buf1_ff;
                  end else if (n_in == 3'd4 && buf1_ff == ESC &&
                               (dec == DELIM || dec == ESC)) begin
                     status_in = ST_OK;
                     rbyte_in  = dec;
                  end
               end
               state_in = BK_REPLY;
               // The first delimiter left at the head no longer closes a frame
               // when the removed bytes had opened one.
               if (fill_in != '0 && delims_in != '0 && p_open_in) begin
                  if (p_pay_in) begin
                     frames_in = frames_in - FW'(1);
                  end else begin
                     state_in = BK_PEEK_READ;
                  end
               end
            end else begin
               state_in = BK_READ;
            end
         end
         BK_PEEK_READ: begin
            ram_en   = 1'b1;
            state_in = BK_PEEK;
         end
         BK_PEEK: begin
            if (ram_rdata != DELIM) begin
               frames_in = frames_ff - FW'(1);
            end
            state_in = BK_REPLY;
         end
         BK_REPLY: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign res.accepted    = acc_ff;
   assign res.read_byte   = rbyte_ff;
   assign res.status      = status_ff;
   assign res.frame_level = 10'(frames_ff);
   assign res.byte_level  = 11'(fill_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         fill_ff       <= '0;
         delims_ff     <= '0;
         frames_ff     <= '0;
         last_delim_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         fill_ff       <= fill_in;
         delims_ff     <= delims_in;
         frames_ff     <= frames_in;
         last_delim_ff <= last_delim_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      n_ff      <= n_in;
      buf1_ff   <= buf1_in;
      buf2_ff   <= buf2_in;
      p_open_ff <= p_open_in;
      p_pay_ff  <= p_pay_in;
      acc_ff    <= acc_in;
      rbyte_ff  <= rbyte_in;
      status_ff <= status_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(STORE_DEPTH))
      else $error("fill count exceeds store depth");

   a_delims_in_fill: assert property (@(posedge clock) disable iff (reset)
      delims_ff <= fill_ff)
      else $error("delimiter count exceeds fill count");

   a_empty_no_frames: assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 |-> frames_ff == '0)
      else $error("frames counted in an empty store");

   a_take_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> state_ff != BK_IDLE)
      else $error("command taken without leaving idle");

endmodule

### design/escaped_frame_byte_fifo.sv
// Top level of the escaped frame byte FIFO: front end, back end and result register.
//
//   channel   direction  handshake    beat
//   request   in         push / full  req_operation, req_data_byte
//   response  out        empty / pop  rsp_accepted .. rsp_byte_level
//
// A push writes its three or four encoded bytes one at a time on the
// single RAM port; an inject writes one byte. A pop reads and then decodes each byte
// it removes (BK_READ, BK_TAKE), and may add a head check (BK_PEEK_READ, BK_PEEK).
// Reset is synchronous and empties the store at once; stored bytes are not cleared.
// Two requests queue ahead of the back end; one response waits in the output
// register while the back end starts on the next request.
`timescale 1ns / 1ps
module escaped_frame_byte_fifo
   import efbf_pkg::*;
#(
   parameter int STORE_DEPTH = 1024,
   parameter int FRAME_LIMIT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_accepted,
   output logic [7:0]  rsp_read_byte,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_frame_level,
   output logic [10:0] rsp_byte_level
);

   logic    cmd_valid, cmd_take;
   cmd_type cmd;
   logic    res_valid, res_ready;
   res_type res;
   logic    out_valid_ff, out_valid_in;
   res_type out_ff;

   efbf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   efbf_back #(.STORE_DEPTH(STORE_DEPTH), .FRAME_LIMIT(FRAME_LIMIT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   assign res_ready = !out_valid_ff || pop;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
      end else if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= res;
      end
   end

   assign empty           = !out_valid_ff;
   assign rsp_accepted    = out_ff.accepted;
   assign rsp_read_byte   = out_ff.read_byte;
   assign rsp_status      = out_ff.status;
   assign rsp_frame_level = out_ff.frame_level;
   assign rsp_byte_level  = out_ff.byte_level;

endmodule

### tb/sv/tb_escaped_frame_byte_fifo.sv
// Testbench for the escaped frame byte FIFO: random and directed beats against a scoreboard.
`timescale 1ns / 1ps
module tb_escaped_frame_byte_fifo;
   import efbf_pkg::*;

   localparam int DEPTH = 1024;
   localparam int LIMIT = 256;
   localparam int AW = $clog2(DEPTH);

   class frame_scoreboard;
      logic [7:0]  ring [DEPTH];
      int unsigned rd_ptr;
      int unsigned wr_ptr;
      int unsigned fill;
      res_type     pending[$];
      int          errors;

      function new();
         rd_ptr = 0;
         wr_ptr = 0;
         fill = 0;
         errors = 0;
      endfunction

      function int unsigned frames_held();
         int unsigned i, n, body;
         bit          open;
         logic [7:0]  b;
         n = 0;
         body = 0;
         open = 0;
         for (i = 0; i < fill; i++) begin
            b = ring[AW'((rd_ptr + i) % DEPTH)];
            if (b == DELIM) begin
               if (open && body > 0) n++;
               open = 1;
               body = 0;
            end else if (open) begin
               body++;
            end
         end
         return n;
      endfunction

      function void put(logic [7:0] b);
         ring[AW'(wr_ptr)] = b;
         wr_ptr = (wr_ptr + 1) % DEPTH;
         fill++;
      endfunction

      function logic [7:0] take();
         logic [7:0] b;
         b = ring[AW'(rd_ptr)];
         rd_ptr = (rd_ptr + 1) % DEPTH;
         fill--;
         return b;
      endfunction

      // Decodes one frame from the head; returns the status code.
      function logic [1:0] decode_frame(output logic [7:0] value);
         logic [7:0] buf4 [4];
         int unsigned n;
         bit          closed;
         logic [7:0]  b, d;
         n = 0;
         closed = 0;
         value = 8'd0;
         while (fill > 0 && !closed) begin
            b = take();
            if (n == 0) begin
               if (b == DELIM) begin
                  buf4[0] = b;
                  n = 1;
               end
            end else begin
               if (n >= MAX_FRAME_BYTES) return ST_INVALID;
               buf4[2'(n)] = b;
               n++;
               if (b == DELIM) closed = 1;
            end
         end
         if (!closed) return ST_INVALID;
         if (n == 3) begin
            if (buf4[1] == DELIM || buf4[1] == ESC) return ST_INVALID;
            value = buf4[1];
            return ST_OK;
         end
         if (n == 4 && buf4[1] == ESC) begin
            d = buf4[2] ^ FLIP;
            if (d != DELIM && d != ESC) return ST_INVALID;
            value = d;
            return ST_OK;
         end
         return ST_INVALID;
      endfunction

      function void note_request(logic [1:0] op, logic [7:0] data);
         res_type    r;
         logic [7:0] v;
         int unsigned len;
         r = '0;
         if (op == OP_PUSH) begin
            len = (data == DELIM || data == ESC) ? 4 : 3;
            if (frames_held() < LIMIT && fill + len <= DEPTH) begin
               put(DELIM);
               if (len == 4) begin
                  put(ESC);
                  put(data ^ FLIP);
               end else begin
                  put(data);
               end
               put(DELIM);
               r.accepted = 1'b1;
            end
         end else if (op == OP_INJECT) begin
            if (fill < DEPTH) begin
               put(data);
               r.accepted = 1'b1;
            end
         end else if (op == OP_POP) begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.status = decode_frame(v);
               if (r.status == ST_OK) r.read_byte = v;
            end
         end
         r.frame_level = 10'(frames_held());
         r.byte_level = 11'(fill);
         pending.push_back(r);
      endfunction

      function void check_response(res_type got);
         res_type want;
         if (pending.size() == 0) begin
            $display("%0t: response with nothing expected: %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.accepted !== want.accepted)
            $display("%0t: accepted expected %0d actual %0d", $time, want.accepted,
                     got.accepted);
         if (got.read_byte !== want.read_byte)
            $display("%0t: read_byte expected %h actual %h", $time, want.read_byte,
                     got.read_byte);
         if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         if (got.frame_level !== want.frame_level)
            $display("%0t: frame_level expected %0d actual %0d", $time, want.frame_level,
                     got.frame_level);
         if (got.byte_level !== want.byte_level)
            $display("%0t: byte_level expected %0d actual %0d", $time, want.byte_level,
                     got.byte_level);
         if (got !== want) errors++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic [1:0]  req_operation = OP_PUSH;
   logic [7:0]  req_data_byte = 8'd0;
   logic        full, empty;
   logic        rsp_accepted;
   logic [7:0]  rsp_read_byte;
   logic [1:0]  rsp_status;
   logic [9:0]  rsp_frame_level;
   logic [10:0] rsp_byte_level;

   int send_idle = 30;
   int recv_idle = 70;
   bit sending_done = 0;

   frame_scoreboard board = new();

   escaped_frame_byte_fifo #(.STORE_DEPTH(DEPTH), .FRAME_LIMIT(LIMIT)) dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_operation(req_operation), .req_data_byte(req_data_byte),
      .empty(empty), .pop(pop), .rsp_accepted(rsp_accepted),
      .rsp_read_byte(rsp_read_byte), .rsp_status(rsp_status),
      .rsp_frame_level(rsp_frame_level), .rsp_byte_level(rsp_byte_level)
   );

   always #4 clock = ~clock;

   // One beat on the request side; the driver holds push across back-to-back beats.
   task automatic send_beat(logic [1:0] op, logic [7:0] data);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      do @(posedge clock); while (full);
      board.note_request(op, data);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && pop && !empty)
         board.check_response({rsp_accepted, rsp_read_byte, rsp_status,
                               rsp_frame_level, rsp_byte_level});
   end

   always @(negedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= recv_idle);
   end

   // Mostly well-formed pushes and pops, with some raw bytes to corrupt frames.
   task automatic random_beat();
      int unsigned pick;
      logic [7:0] d;
      pick = $urandom_range(99);
      case ($urandom_range(3))
         0: d = DELIM;
         1: d = ESC;
         default: d = 8'($urandom_range(255));
      endcase
      if (pick < 48) send_beat(OP_PUSH, d);
      else if (pick < 90) send_beat(OP_POP, d);
      else if (pick < 98) send_beat(OP_INJECT, d);
      else send_beat(OP_NONE, d);
   endtask

   initial begin
      int i;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_beat(OP_POP, 8'd0);
      send_beat(OP_PUSH, 8'h00);
      send_beat(OP_PUSH, 8'hFF);
      send_beat(OP_PUSH, DELIM);
      send_beat(OP_PUSH, ESC);
      send_beat(OP_NONE, 8'hAA);
      for (i = 0; i < 4; i++) send_beat(OP_POP, 8'hFF);
      send_beat(OP_POP, 8'h00);
      // Raw bytes with no delimiter, then an empty frame, a stray byte between two
      // valid frames, a pop on an empty store and a bad escape.
      send_beat(OP_INJECT, 8'h55);
      send_beat(OP_POP, 8'h00);
      send_beat(OP_INJECT, DELIM);
      send_beat(OP_INJECT, DELIM);
      send_beat(OP_POP, 8'h00);
      send_beat(OP_PUSH, 8'h12);
      send_beat(OP_INJECT, 8'h34);
      send_beat(OP_PUSH, 8'h56);
      send_beat(OP_POP, 8'h00);
      send_beat(OP_POP, 8'h00);
      send_beat(OP_POP, 8'h00);
      send_beat(OP_INJECT, DELIM);
      send_beat(OP_INJECT, ESC);
      send_beat(OP_INJECT, 8'h01);
      send_beat(OP_INJECT, DELIM);
      send_beat(OP_POP, 8'h00);
      for (i = 0; i < 300; i++) random_beat();
      send_idle = 70;
      recv_idle = 30;
      // Fill to the frame limit and the byte limit, then pop twenty frames.
      for (i = 0; i < 270; i++) send_beat(OP_PUSH, 8'($urandom_range(255)));
      for (i = 0; i < 300; i++) send_beat(OP_INJECT, 8'($urandom_range(255)));
      for (i = 0; i < 20; i++) send_beat(OP_POP, 8'h00);
      for (i = 0; i < 300; i++) random_beat();
      send_idle = 0;
      recv_idle = 0;
      for (i = 0; i < 300; i++) send_beat(OP_POP, 8'h00);
      for (i = 0; i < 300; i++) random_beat();
      push <= 1'b0;
      sending_done = 1;
   end

   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0) $display("tb_escaped_frame_byte_fifo OK");
      else $display("tb_escaped_frame_byte_fifo NOT OK");
      $finish;
   end

   initial begin
      #40ms;
      $display("tb_escaped_frame_byte_fifo NOT OK");
      $finish;
   end

endmodule
